FILE: src/bce_pkg.sv
// Shared types and codes for the beacon channel extractor.
// No dependencies.
package bce_pkg;

	typedef logic [1:0] phase_t;

	localparam phase_t PH_HEADER = 2'd0;
	localparam phase_t PH_TAG    = 2'd1;
	localparam phase_t PH_LEN    = 2'd2;
	localparam phase_t PH_VALUE  = 2'd3;

	// Element tags that carry the channel
	localparam logic [7:0] TAG_DS_PARAM = 8'h03;
	localparam logic [7:0] TAG_HT_INFO  = 8'h3D;

	localparam logic [7:0] SKIP_RESET = 8'd36;
	localparam logic [7:0] POS_MAX    = 8'hFF;

	function automatic logic tag_matches(input logic [7:0] t);
		return (t == TAG_DS_PARAM) || (t == TAG_HT_INFO);
	endfunction

endpackage

FILE: src/beacon_channel_extractor_core.sv
// Beacon channel extractor: byte-wise scan of 802.11 information elements.
// Depends on bce_pkg.
//
// Usage:
//   Frame bytes enter on data_byte/last with data_valid; the block raises
//   data_stall to hold them off. An item is taken at a clock edge with
//   data_valid high and data_stall low. One result per frame leaves on
//   channel with channel_valid, on the byte marked last; the receiver
//   holds it off with channel_stall.
//   skip_bytes_wr_en/skip_bytes_wr_data write the header length (bytes
//   before the first element, 36 after reset); write only while idle.
// Timing:
//   Each byte is captured in an input register, then the parse state is
//   updated by one level of compare/decrement logic. The result of a last
//   byte goes from the input register to the output register. One byte
//   per cycle is sustained unless a last byte is held by a stalled result.
// Reset:
//   arst_n clears the input and output valid flags, the parse state and sets
//   skip_bytes back to 36.
// Stall:
//   A stalled result is held in the output register. Bytes that are not
//   last keep flowing; a last byte waits in the input register until the
//   output register frees, and data_stall rises while it waits.
module beacon_channel_extractor_core
	import bce_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       skip_bytes_wr_en,
	input  logic [7:0] skip_bytes_wr_data,
	input  logic       data_valid,
	output logic       data_stall,
	input  logic [7:0] data_byte,
	input  logic       last,
	output logic       channel_valid,
	input  logic       channel_stall,
	output logic [7:0] channel
);

	// configuration
	logic [7:0] skip_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// per-frame parse state
	logic [7:0] pos_q;
	phase_t     phase_q;
	logic [7:0] tag_q;
	logic [7:0] remain_q;
	logic       found_q;
	logic [7:0] chan_q;

	// output register
	logic       out_valid_q;
	logic [7:0] out_chan_q;

	logic       out_free;
	logic       adv;
	logic       take;

	phase_t     ph;
	phase_t     nxt_phase;
	logic [7:0] nxt_tag;
	logic [7:0] nxt_remain;
	logic       nxt_found;
	logic [7:0] nxt_chan;
	logic [7:0] nxt_pos;

	// output register can load when empty or being drained this cycle
	assign out_free   = !out_valid_q || !channel_stall;
	// a last byte needs room for its result
	assign adv        = valid_s1 && (!last_s1 || out_free);
	assign data_stall = valid_s1 && !adv;
	assign take       = data_valid && !data_stall;

	assign channel_valid = out_valid_q;
	assign channel       = out_chan_q;

	// Parse step for the byte in the input register
	always_comb begin
		ph         = phase_q;
		nxt_phase  = phase_q;
		nxt_tag    = tag_q;
		nxt_remain = remain_q;
		nxt_found  = found_q;
		nxt_chan   = chan_q;
		if (!found_q) begin
			// header ends once the position reaches skip_bytes
			if (ph == PH_HEADER && pos_q >= skip_q) begin
				ph = PH_TAG;
			end
			unique case (ph)
				PH_HEADER: begin
					nxt_phase = PH_HEADER;
				end
				PH_TAG: begin
					nxt_tag   = byte_s1;
					nxt_phase = PH_LEN;
				end
				PH_LEN: begin
					nxt_remain = byte_s1;
					// matching element of length zero still latches the next byte
					if (tag_matches(tag_q) || byte_s1 != 8'd0) begin
						nxt_phase = PH_VALUE;
					end else begin
						nxt_phase = PH_TAG;
					end
				end
				PH_VALUE: begin
					if (tag_matches(tag_q)) begin
						nxt_chan  = byte_s1;
						nxt_found = 1'b1;
					end else begin
						nxt_remain = remain_q - 8'd1;
						nxt_phase  = (remain_q == 8'd1) ? PH_TAG : PH_VALUE;
					end
				end
				default: begin
					nxt_phase = PH_HEADER;
				end
			endcase
		end
		nxt_pos = (pos_q == POS_MAX) ? pos_q : pos_q + 8'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= SKIP_RESET;
		end else if (skip_bytes_wr_en) begin
			skip_q <= skip_bytes_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= data_byte;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 8'd0;
			phase_q  <= PH_HEADER;
			tag_q    <= 8'd0;
			remain_q <= 8'd0;
			found_q  <= 1'b0;
			chan_q   <= 8'd0;
		end else if (adv) begin
			if (last_s1) begin
				// frame done: start over
				pos_q    <= 8'd0;
				phase_q  <= PH_HEADER;
				tag_q    <= 8'd0;
				remain_q <= 8'd0;
				found_q  <= 1'b0;
				chan_q   <= 8'd0;
			end else begin
				pos_q    <= nxt_pos;
				phase_q  <= nxt_phase;
				tag_q    <= nxt_tag;
				remain_q <= nxt_remain;
				found_q  <= nxt_found;
				chan_q   <= nxt_chan;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!channel_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			out_chan_q <= nxt_found ? nxt_chan : 8'd0;
		end
	end

	// A frame end always produces a result next cycle
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> out_valid_q)
		else $error("frame end did not load a result");

	// Frame state is cleared after a frame end
	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> (pos_q == 8'd0) && !found_q && (phase_q == PH_HEADER))
		else $error("frame state not cleared");

	// A latched channel only comes from the value phase
	a_found_phase: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> phase_q == PH_VALUE)
		else $error("found outside value phase");

	// Input is held off only while a last byte waits in the input register for a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		data_stall |-> valid_s1 && last_s1 && out_valid_q && channel_stall)
		else $error("spurious input stall");

endmodule
